@@ src/smac_pkg.sv @@
// shared types, codes and constants of the shadow memory access checker
`default_nettype none

package smac_pkg;

   // fixed field widths
   localparam int ADDR_W   = 64;
   localparam int CNT_W    = 13;
   localparam int CODE_W   = 8;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 3;
   // granule offset inside one span: a byte count plus start offset, divided by 8
   localparam int GOFF_W   = CNT_W - 2;

   // parameter defaults
   localparam int DEF_SHADOW_ENTRIES = 65536;
   localparam int DEF_MAX_SPAN_BYTES = 4096;

   // shadow codes
   localparam logic [CODE_W-1:0] POISON_MIN      = 8'hF9;
   localparam logic [CODE_W-1:0] RESET_CODE      = 8'hFF;
   localparam logic [CODE_W-1:0] GRANULE_BYTES   = 8'd8;
   localparam logic [CODE_W-1:0] FREED_RESET     = 8'd251;
   localparam logic [CODE_W-1:0] REDZONE_RESET   = 8'd249;

   // operation modes
   localparam logic [MODE_W-1:0] MODE_READ     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_UNPOISON = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POISON   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FREE     = 3'd4;
   localparam logic [MODE_W-1:0] MODE_REGISTER = 3'd5;

   // result status
   localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_SKIPPED     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DOUBLE_FREE = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_REJECT      = 3'd4;

   // register file: 64-bit registers at 8-byte strides
   localparam int REG_IDX_W = 3;
   localparam int CSR_AW    = REG_IDX_W + 3;
   localparam int CSR_DW    = 64;
   localparam logic [REG_IDX_W-1:0] REG_CHECKS_ENABLED = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW_BASE    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW_END     = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FREED_CODE     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_REDZONE_CODE   = 3'd4;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] address;
      logic [CNT_W-1:0]  byte_count;
      logic [CNT_W-1:0]  total_count;
      logic [CODE_W-1:0] poison_code;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                was_write;
      logic [CODE_W-1:0]   start_shadow;
   } rsp_item_type;

   typedef struct packed {
      logic              checks_enabled;
      logic [ADDR_W-1:0] window_base;
      logic [ADDR_W-1:0] window_end;
      logic [CODE_W-1:0] freed_code;
      logic [CODE_W-1:0] redzone_code;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WIN,
      ST_BASE,
      ST_SPAN,
      ST_BOUND,
      ST_CHK_RD,
      ST_CHK_EV,
      ST_FREE_RD,
      ST_FREE_EV,
      ST_FILL_A,
      ST_FILL_B,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

@@ src/smac_ram.sv @@
// generic single-port ram with registered read
`default_nettype none

module smac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ src/smac_csr.sv @@
// configuration registers behind the apb-style port
`default_nettype none

module smac_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [smac_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [smac_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [smac_pkg::CSR_DW-1:0] csr_prdata,
   output logic                             csr_pready,
   output smac_pkg::cfg_type                cfg
);
   import smac_pkg::*;

   cfg_type              cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr;

   assign reg_idx    = csr_paddr[CSR_AW-1:3];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (reg_idx)
            REG_CHECKS_ENABLED: cfg_in.checks_enabled = csr_pwdata[0];
            REG_WINDOW_BASE:    cfg_in.window_base    = csr_pwdata;
            REG_WINDOW_END:     cfg_in.window_end     = csr_pwdata;
            REG_FREED_CODE:     cfg_in.freed_code     = csr_pwdata[CODE_W-1:0];
            REG_REDZONE_CODE:   cfg_in.redzone_code   = csr_pwdata[CODE_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_CHECKS_ENABLED: csr_prdata = CSR_DW'(cfg_ff.checks_enabled);
         REG_WINDOW_BASE:    csr_prdata = cfg_ff.window_base;
         REG_WINDOW_END:     csr_prdata = cfg_ff.window_end;
         REG_FREED_CODE:     csr_prdata = CSR_DW'(cfg_ff.freed_code);
         REG_REDZONE_CODE:   csr_prdata = CSR_DW'(cfg_ff.redzone_code);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.checks_enabled <= 1'b0;
         cfg_ff.window_base    <= '0;
         cfg_ff.window_end     <= '0;
         cfg_ff.freed_code     <= FREED_RESET;
         cfg_ff.redzone_code   <= REDZONE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ src/smac_engine.sv @@
// sequencer that walks the shadow store one granule at a time
`default_nettype none

module smac_engine #(
   parameter int SHADOW_ENTRIES = smac_pkg::DEF_SHADOW_ENTRIES,
   parameter int MAX_SPAN_BYTES = smac_pkg::DEF_MAX_SPAN_BYTES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire smac_pkg::req_item_type req_item,
   input  wire smac_pkg::cfg_type      cfg,
   output logic                        res_valid,
   output smac_pkg::rsp_item_type      res_item,
   input  wire logic                   out_free
);
   import smac_pkg::*;

   localparam int AW      = $clog2(SHADOW_ENTRIES);
   localparam int SUM_W   = ((AW > GOFF_W) ? AW : GOFF_W) + 1;
   localparam int MS_W    = $clog2(MAX_SPAN_BYTES + 1);
   localparam int LEN_W   = (MS_W > CNT_W) ? MS_W : CNT_W;
   localparam int LOW_W   = CNT_W + 1;
   localparam int GADDR_W = ADDR_W - 3;

   state_type         state_ff, state_in;
   req_item_type      item_ff, item_in;
   rsp_item_type      res_ff, res_in;
   logic [AW-1:0]     first_ff, first_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [GOFF_W-1:0] g_ff, g_in;
   logic [GOFF_W-1:0] span_ff, span_in;
   logic [GOFF_W-1:0] fa_last_ff, fa_last_in;
   logic [GOFF_W-1:0] rz_first_ff, rz_first_in;
   logic [GOFF_W-1:0] rz_last_ff, rz_last_in;
   logic              has_b_ff, has_b_in;
   logic [CODE_W-1:0] start_ff, start_in;

   // ram port
   logic              ram_we;
   logic [AW-1:0]     ram_addr;
   logic [CODE_W-1:0] ram_wdata;
   logic [CODE_W-1:0] ram_rdata;

   // item decode
   logic              is_check, bad_mode, is_reg, cnt_nz, skip, too_long;
   logic [GADDR_W:0]  gdiff;
   logic              below, beyond;
   logic [LOW_W-1:0]  lo_x, cnt_x, tot_x, chk_end, ceil_x, rs_x, re_x, re_m1;
   logic [GOFF_W-1:0] ceil_g, fa_last_calc, rs_g, re_g, chk_span, fill_span, span_calc;
   logic              rz_gt;
   logic [SUM_W-1:0]  bound_sum, gsum;
   logic              out_store, clr_last;
   logic              last_chk, last_a, last_b;
   logic [2:0]        end_off;
   logic              fault, dbl_free;
   logic [CODE_W-1:0] chk_start, fill_a_data;

   smac_ram #(
      .WIDTH(CODE_W),
      .DEPTH(SHADOW_ENTRIES)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   assign is_check = (item_ff.mode == MODE_READ) || (item_ff.mode == MODE_WRITE);
   assign bad_mode = item_ff.mode > MODE_REGISTER;
   assign is_reg   = item_ff.mode == MODE_REGISTER;
   assign cnt_nz   = item_ff.byte_count != '0;
   assign skip     = bad_mode || (is_check && (!cfg.checks_enabled
                     || item_ff.address < cfg.window_base
                     || item_ff.address >= cfg.window_end));
   assign too_long = (LEN_W'(item_ff.byte_count) > LEN_W'(MAX_SPAN_BYTES))
                     || (is_reg && (LEN_W'(item_ff.total_count) > LEN_W'(MAX_SPAN_BYTES)));

   // start granule relative to the window base granule
   assign gdiff  = {1'b0, item_ff.address[ADDR_W-1:3]} - {1'b0, cfg.window_base[ADDR_W-1:3]};
   assign below  = gdiff[GADDR_W];
   assign beyond = gdiff[GADDR_W-1:0] >= GADDR_W'(SHADOW_ENTRIES);

   // span arithmetic, all narrow
   assign lo_x         = LOW_W'(item_ff.address[2:0]);
   assign cnt_x        = LOW_W'(item_ff.byte_count);
   assign tot_x        = LOW_W'(item_ff.total_count);
   assign chk_end      = lo_x + cnt_x - LOW_W'(1);
   assign ceil_x       = cnt_x + LOW_W'(7);
   assign ceil_g       = ceil_x[LOW_W-1:3];
   assign fa_last_calc = ceil_g - GOFF_W'(1);
   assign rs_x         = lo_x + cnt_x + LOW_W'(7);
   assign rs_g         = rs_x[LOW_W-1:3];
   assign re_x         = lo_x + tot_x;
   assign re_m1        = re_x - LOW_W'(1);
   assign re_g         = re_m1[LOW_W-1:3];
   assign rz_gt        = re_x > {rs_g, 3'b000};
   assign chk_span     = cnt_nz ? chk_end[LOW_W-1:3] : '0;
   assign fill_span    = cnt_nz ? fa_last_calc : '0;

   always_comb begin
      if (is_check) begin
         span_calc = chk_span;
      end else if (is_reg && rz_gt && (re_g > fill_span)) begin
         span_calc = re_g;
      end else begin
         span_calc = fill_span;
      end
   end

   assign bound_sum = SUM_W'(first_ff) + SUM_W'(span_ff);
   assign out_store = bound_sum >= SUM_W'(SHADOW_ENTRIES);
   assign gsum      = SUM_W'(first_ff) + SUM_W'(g_ff);
   assign ram_addr  = (state_ff == ST_CLEAR) ? clr_ff : gsum[AW-1:0];
   assign clr_last  = clr_ff == AW'(SHADOW_ENTRIES - 1);

   assign last_chk = g_ff == span_ff;
   assign last_a   = g_ff == fa_last_ff;
   assign last_b   = g_ff == rz_last_ff;

   // highest byte offset of the access inside the current granule
   assign end_off   = last_chk ? (item_ff.address[2:0] + item_ff.byte_count[2:0] - 3'd1)
                               : 3'd7;
   assign fault     = (ram_rdata >= POISON_MIN)
                      || ((ram_rdata != '0) && (ram_rdata < GRANULE_BYTES)
                          && (CODE_W'(end_off) >= ram_rdata));
   assign chk_start = (g_ff == '0) ? ram_rdata : start_ff;
   assign dbl_free  = ram_rdata == cfg.freed_code;

   always_comb begin
      case (item_ff.mode)
         MODE_POISON: fill_a_data = item_ff.poison_code;
         MODE_FREE:   fill_a_data = cfg.freed_code;
         default:     fill_a_data = (g_ff == GOFF_W'(item_ff.byte_count[CNT_W-1:3]))
                                    ? CODE_W'(item_ff.byte_count[2:0]) : '0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_last) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_WIN;
         ST_WIN:   state_in = (skip || too_long) ? ST_DONE : ST_BASE;
         ST_BASE:  state_in = (below || beyond) ? ST_DONE : ST_SPAN;
         ST_SPAN:  state_in = ST_BOUND;
         ST_BOUND: begin
            if (out_store) begin
               state_in = ST_DONE;
            end else if (is_check) begin
               state_in = cnt_nz ? ST_CHK_RD : ST_DONE;
            end else if (item_ff.mode == MODE_FREE) begin
               state_in = ST_FREE_RD;
            end else if (cnt_nz) begin
               state_in = ST_FILL_A;
            end else if (is_reg && has_b_ff) begin
               state_in = ST_FILL_B;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CHK_RD:  state_in = ST_CHK_EV;
         ST_CHK_EV:  state_in = (fault || last_chk) ? ST_DONE : ST_CHK_RD;
         ST_FREE_RD: state_in = ST_FREE_EV;
         ST_FREE_EV: state_in = (dbl_free || !cnt_nz) ? ST_DONE : ST_FILL_A;
         ST_FILL_A: begin
            if (last_a) begin
               state_in = (is_reg && has_b_ff) ? ST_FILL_B : ST_DONE;
            end
         end
         ST_FILL_B: if (last_b) state_in = ST_DONE;
         ST_DONE:   if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      item_in     = item_ff;
      res_in      = res_ff;
      first_in    = first_ff;
      clr_in      = clr_ff;
      g_in        = g_ff;
      span_in     = span_ff;
      fa_last_in  = fa_last_ff;
      rz_first_in = rz_first_ff;
      rz_last_in  = rz_last_ff;
      has_b_in    = has_b_ff;
      start_in    = start_ff;
      ram_we      = 1'b0;
      ram_wdata   = '0;
      res_valid   = 1'b0;
      req_stall   = state_ff != ST_IDLE;
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = RESET_CODE;
            clr_in    = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_item;
               res_in  = '0;
            end
         end
         ST_WIN: begin
            if (skip) begin
               res_in.status = STATUS_SKIPPED;
            end else if (too_long) begin
               res_in.status = STATUS_REJECT;
            end
         end
         ST_BASE: begin
            first_in = gdiff[AW-1:0];
            if (below || beyond) begin
               res_in.status = STATUS_REJECT;
            end
         end
         ST_SPAN: begin
            span_in     = span_calc;
            fa_last_in  = fa_last_calc;
            rz_first_in = rs_g;
            rz_last_in  = re_g;
            has_b_in    = is_reg && rz_gt;
         end
         ST_BOUND: begin
            g_in = '0;
            if (out_store) begin
               res_in.status = STATUS_REJECT;
            end else if (is_reg && !cnt_nz) begin
               g_in = rz_first_ff;
            end
         end
         ST_CHK_EV: begin
            start_in = chk_start;
            g_in     = g_ff + GOFF_W'(1);
            if (fault) begin
               res_in.status       = STATUS_INVALID;
               res_in.was_write    = item_ff.mode == MODE_WRITE;
               res_in.start_shadow = chk_start;
            end
         end
         ST_FREE_EV: begin
            if (dbl_free) begin
               res_in.status       = STATUS_DOUBLE_FREE;
               res_in.start_shadow = ram_rdata;
            end
         end
         ST_FILL_A: begin
            ram_we    = 1'b1;
            ram_wdata = fill_a_data;
            g_in      = last_a ? rz_first_ff : g_ff + GOFF_W'(1);
         end
         ST_FILL_B: begin
            ram_we    = 1'b1;
            ram_wdata = cfg.redzone_code;
            g_in      = g_ff + GOFF_W'(1);
         end
         ST_DONE:  res_valid = 1'b1;
         default:  res_valid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_ff      <= res_in;
      first_ff    <= first_in;
      g_ff        <= g_in;
      span_ff     <= span_in;
      fa_last_ff  <= fa_last_in;
      rz_first_ff <= rz_first_in;
      rz_last_ff  <= rz_last_in;
      has_b_ff    <= has_b_in;
      start_ff    <= start_in;
   end

   assign res_item = res_ff;

   a_no_write_on_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHK_RD || state_ff == ST_CHK_EV
       || state_ff == ST_FREE_RD || state_ff == ST_FREE_EV) |-> !ram_we)
      else $error("shadow store written during a lookup");

   a_write_in_store: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != ST_CLEAR) |-> (gsum < SUM_W'(SHADOW_ENTRIES)))
      else $error("granule write beyond the shadow store");

   a_clear_ends_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_last) |=> (state_ff == ST_IDLE))
      else $error("clearing pass did not hand over to idle");

   a_write_flag_on_fault: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ff.was_write) |-> (res_ff.status == STATUS_INVALID))
      else $error("write flag set on a non-fault result");

   a_take_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_WIN))
      else $error("accepted item did not start the sequence");

endmodule

`default_nettype wire

@@ src/shadow_memory_access_checker_unit.sv @@
// top level of the shadow memory access checker
`default_nettype none

// Shadow memory access checker. The block keeps one shadow byte per 8-byte
// granule of a configurable address window (0 = all valid, 1..7 = that many
// leading bytes valid, 0xF9 and up = poisoned) and runs one operation per item:
// read or write check, unpoison, poison, free with double-free detection, or
// object registration with a rounded redzone. Each item gives exactly one
// result item. All work goes through a single sequencer that owns the one port
// of the shadow ram, so granules are handled one after another and the block
// takes one item at a time. After reset the sequencer sweeps the whole store to
// 0xFF, one entry per cycle; items are held off during that sweep while register
// writes are taken as usual. A check reads and then evaluates each granule in
// turn, as the ram read is registered; unpoison, poison and register write their
// granules one after another, free first reads its start granule for the
// double-free check, and an item skipped or rejected on its mode, window or length
// ends without touching the store. The result sits in an output register, so the
// next item is taken while it waits.

module shadow_memory_access_checker_unit #(
   parameter int SHADOW_ENTRIES = smac_pkg::DEF_SHADOW_ENTRIES,
   parameter int MAX_SPAN_BYTES = smac_pkg::DEF_MAX_SPAN_BYTES
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // item input
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire smac_pkg::req_item_type      req_item,
   // result output
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output smac_pkg::rsp_item_type           rsp_item,
   // register port
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [smac_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [smac_pkg::CSR_DW-1:0] csr_pwdata,
   output logic      [smac_pkg::CSR_DW-1:0] csr_prdata,
   output logic                             csr_pready
);
   import smac_pkg::*;

   cfg_type      cfg;
   logic         res_valid;
   rsp_item_type res_item;
   logic         out_free;
   logic         out_load;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   smac_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg        (cfg)
   );

   smac_engine #(
      .SHADOW_ENTRIES(SHADOW_ENTRIES),
      .MAX_SPAN_BYTES(MAX_SPAN_BYTES)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .cfg      (cfg),
      .res_valid(res_valid),
      .res_item (res_item),
      .out_free (out_free)
   );

   // the output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = res_valid && out_free;

   always_comb begin
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
      rsp_item_in  = out_load ? res_item : rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

@@ bench/shadow_memory_access_checker_unit_test.sv @@
// self-checking bench for the shadow memory access checker: directed and random items
module shadow_memory_access_checker_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import smac_pkg::*;

   // generous bound: worst-case walks for every item plus the clearing sweep, several times over
   localparam int unsigned CYCLE_LIMIT = 7_000_000;

   // keeps its own shadow store and register copy, predicts each item's outcome
   class shadow_tracker;
      bit [7:0]     shadow [DEF_SHADOW_ENTRIES];
      bit           checks_on;
      bit [63:0]    win_base;
      bit [63:0]    win_end;
      bit [7:0]     freed;
      bit [7:0]     redzone;
      rsp_item_type outcomes [$];
      int           mismatches;

      function new();
         foreach (shadow[g]) shadow[g] = RESET_CODE;
         checks_on  = 1'b0;
         win_base   = '0;
         win_end    = '0;
         freed      = FREED_RESET;
         redzone    = REDZONE_RESET;
         mismatches = 0;
      endfunction

      function void set_reg(logic [REG_IDX_W-1:0] idx, bit [63:0] value);
         case (idx)
            REG_CHECKS_ENABLED: checks_on = value[0];
            REG_WINDOW_BASE:    win_base  = value;
            REG_WINDOW_END:     win_end   = value;
            REG_FREED_CODE:     freed     = value[7:0];
            REG_REDZONE_CODE:   redzone   = value[7:0];
            default: ;
         endcase
      endfunction

      function void fill(bit [63:0] from, bit [63:0] count, bit [7:0] code);
         for (bit [63:0] k = 0; k < count; k++) shadow[from + k] = code;
      endfunction

      function void clear_span(bit [63:0] from, bit [63:0] n);
         fill(from, n >> 3, 8'h00);
         if (n[2:0] != 3'd0) shadow[from + (n >> 3)] = {5'd0, n[2:0]};
      endfunction

      function rsp_item_type access_outcome(req_item_type r);
         rsp_item_type res;
         bit [63:0]    addr, cnt, tot, lo, first, span, rs, re, pos, i;
         bit [7:0]     code;
         res  = '0;
         addr = r.address;
         cnt  = 64'(r.byte_count);
         tot  = 64'(r.total_count);
         lo   = addr & 64'h7;
         rs   = '0;
         re   = '0;
         if (r.mode > MODE_REGISTER) begin
            res.status = STATUS_SKIPPED;
            return res;
         end
         if (r.mode <= MODE_WRITE && (!checks_on || addr < win_base || addr >= win_end)) begin
            res.status = STATUS_SKIPPED;
            return res;
         end
         if (cnt > DEF_MAX_SPAN_BYTES ||
             (r.mode == MODE_REGISTER && tot > DEF_MAX_SPAN_BYTES)) begin
            res.status = STATUS_REJECT;
            return res;
         end
         if ((addr >> 3) < (win_base >> 3)) begin
            res.status = STATUS_REJECT;
            return res;
         end
         first = (addr >> 3) - (win_base >> 3);
         if (first >= DEF_SHADOW_ENTRIES) begin
            res.status = STATUS_REJECT;
            return res;
         end
         // last granule touched, relative to the start granule
         if (r.mode <= MODE_WRITE) begin
            span = (cnt == 0) ? 64'd0 : (lo + cnt - 1) >> 3;
         end else begin
            span = (cnt == 0) ? 64'd0 : ((cnt + 7) >> 3) - 1;
            if (r.mode == MODE_REGISTER) begin
               rs = (lo + cnt + 7) & ~64'h7;
               re = lo + tot;
               if (re > rs && ((re - 1) >> 3) > span) span = (re - 1) >> 3;
            end
         end
         if (first + span >= DEF_SHADOW_ENTRIES) begin
            res.status = STATUS_REJECT;
            return res;
         end
         case (r.mode)
            MODE_READ, MODE_WRITE: begin
               for (i = 0; i < cnt; i++) begin
                  pos  = lo + i;
                  code = shadow[first + (pos >> 3)];
                  if (code != 8'h00 && (code >= POISON_MIN || pos[2:0] >= code)) begin
                     res.status       = STATUS_INVALID;
                     res.was_write    = (r.mode == MODE_WRITE);
                     res.start_shadow = shadow[first];
                     return res;
                  end
               end
            end
            MODE_UNPOISON: clear_span(first, cnt);
            MODE_POISON:   fill(first, (cnt + 7) >> 3, r.poison_code);
            MODE_FREE: begin
               if (shadow[first] == freed) begin
                  res.status       = STATUS_DOUBLE_FREE;
                  res.start_shadow = shadow[first];
               end else begin
                  fill(first, (cnt + 7) >> 3, freed);
               end
            end
            default: begin
               clear_span(first, cnt);
               if (re > rs) fill(first + (rs >> 3), (re - rs + 7) >> 3, redzone);
            end
         endcase
         return res;
      endfunction

      function void take_request(req_item_type r);
         outcomes.push_back(access_outcome(r));
      endfunction

      function void match_result(rsp_item_type got);
         rsp_item_type want;
         if (outcomes.size() == 0) begin
            $error("result item with nothing pending: status %0d", got.status);
            mismatches++;
            return;
         end
         want = outcomes.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
         end
         if (got.was_write !== want.was_write) begin
            $error("was_write: expected %0d, got %0d", want.was_write, got.was_write);
            mismatches++;
         end
         if (got.start_shadow !== want.start_shadow) begin
            $error("start_shadow: expected 0x%02h, got 0x%02h",
                   want.start_shadow, got.start_shadow);
            mismatches++;
         end
      endfunction
   endclass

   // clock, reset and block ports, all known from time zero
   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   req_item_type        req_item    = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   rsp_item_type        rsp_item;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   shadow_tracker tracker = new;
   bit            steady  = 1'b0;   // set for a stretch with no idling on either side
   int unsigned   cycles  = 0;
   int            items_sent = 0;

   shadow_memory_access_checker_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5ns clock = 1'b1;
      #5ns clock = 1'b0;
   end

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("shadow_memory_access_checker_unit_test: FAIL");
         $finish;
      end
   end

   // result side: random back-pressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 34);
   end

   // result side: values sampled before the edge updates them
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.match_result(rsp_item);
   end

   // one register write: setup phase, access phase, then back to idle;
   // called and returns on a falling edge
   task automatic write_reg(logic [REG_IDX_W-1:0] idx, bit [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.set_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(bit en, bit [63:0] base, bit [63:0] top,
                            bit [7:0] freed_code, bit [7:0] redzone_code);
      write_reg(REG_CHECKS_ENABLED, {63'd0, en});
      write_reg(REG_WINDOW_BASE, base);
      write_reg(REG_WINDOW_END, top);
      write_reg(REG_FREED_CODE, {56'd0, freed_code});
      write_reg(REG_REDZONE_CODE, {56'd0, redzone_code});
   endtask

   // offer one item, holding it until taken; valid stays high on return
   // so the next call either keeps it up or drops it, never both in one step
   task automatic issue(logic [MODE_W-1:0] mode, bit [63:0] addr, int cnt,
                        int tot = 0, int code = 0);
      req_item_type r;
      r.mode        = mode;
      r.address     = addr;
      r.byte_count  = CNT_W'(cnt);
      r.total_count = CNT_W'(tot);
      r.poison_code = CODE_W'(code);
      while (!steady && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_request(r);
      items_sent++;
      @(negedge clock);
   endtask

   // drop valid and let every pending result come back, plus a short settle
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.outcomes.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // mostly a hot region at the window start so objects collide, some near the
   // top of the store, below the window, or anywhere in the address space
   function automatic bit [63:0] pick_address();
      int        roll;
      bit [63:0] g0;
      roll = $urandom_range(0, 99);
      g0   = tracker.win_base & ~64'h7;
      if (roll < 70) return g0 + 64'($urandom_range(0, 4095));
      if (roll < 80) return g0 + 64'h8_0000 - 64'($urandom_range(1, 4200));
      if (roll < 88) return g0 + 64'($urandom_range(0, 32'h7_FFFF));
      if (roll < 93) return tracker.win_base - 64'($urandom_range(1, 64));
      return {$urandom, $urandom};
   endfunction

   // short lengths dominate; a few long walks and a few over the span limit
   function automatic int pick_count();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80) return $urandom_range(0, 40);
      if (roll < 90) return $urandom_range(41, 4095);
      if (roll < 94) return DEF_MAX_SPAN_BYTES;
      if (roll < 97) return $urandom_range(DEF_MAX_SPAN_BYTES + 1, 8191);
      return $urandom_range(0, 8);
   endfunction

   // register an object, touch it in and around its redzone, maybe poison part of it,
   // free it, then maybe use it after free or free it twice
   task automatic object_life();
      bit [63:0] obj;
      int        n, t;
      obj = pick_address();
      if ($urandom_range(0, 1)) obj = obj & ~64'h7;
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 48) : pick_count();
      t = ($urandom_range(0, 9) < 8) ? n + $urandom_range(0, 40) : pick_count();
      issue(MODE_REGISTER, obj, n, t);
      repeat ($urandom_range(1, 4)) begin
         issue($urandom_range(0, 1) ? MODE_WRITE : MODE_READ,
               obj + 64'($urandom_range(0, t + 8)) - 64'd4, $urandom_range(0, 16));
      end
      if ($urandom_range(0, 3) == 0) begin
         issue(MODE_POISON, obj + 64'(8 * $urandom_range(0, 3)), $urandom_range(0, 24), 0,
               $urandom_range(0, 255));
      end
      issue(MODE_FREE, obj, t);
      if ($urandom_range(0, 1)) issue(MODE_READ, obj, $urandom_range(1, 8));
      if ($urandom_range(0, 9) < 4) issue(MODE_FREE, obj, $urandom_range(0, 32));
   endtask

   task automatic noise_item();
      issue(MODE_W'($urandom_range(0, 7)), pick_address(), pick_count(), pick_count(),
            $urandom_range(0, 255));
   endtask

   initial begin
      int        target;
      bit [63:0] base;
      // reset held from time zero, released on a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset configuration: checks off, empty window
      issue(MODE_READ, 64'h0, 8);
      issue(MODE_W'(6), 64'h10, 8);
      issue(MODE_W'(7), 64'h18, 8, 8, 8'hAA);
      drain();

      configure(1'b1, 64'h0, '1, POISON_MIN, RESET_CODE);
      // object with unaligned start and a redzone
      issue(MODE_REGISTER, 64'h13, 13, 40);
      // offset is not added on unpoison, so a check from the same address faults
      issue(MODE_READ, 64'h13, 13);
      issue(MODE_READ, 64'h10, 13);
      issue(MODE_WRITE, 64'h10, 14);
      issue(MODE_READ, 64'h10, 0);
      // untouched store is fully poisoned
      issue(MODE_READ, 64'h1000, 1);
      // codes between 8 and the poison floor behave as fully valid
      issue(MODE_POISON, 64'h100, 16, 0, 8'h80);
      issue(MODE_READ, 64'h100, 16);
      issue(MODE_POISON, 64'h200, 8, 0, POISON_MIN);
      issue(MODE_WRITE, 64'h200, 1);
      // free then double free; zero-length free writes nothing
      issue(MODE_FREE, 64'h10, 16);
      issue(MODE_FREE, 64'h10, 16);
      issue(MODE_FREE, 64'h300, 0);
      // longest span and one byte past it
      issue(MODE_UNPOISON, 64'h4000, DEF_MAX_SPAN_BYTES);
      issue(MODE_READ, 64'h4000, DEF_MAX_SPAN_BYTES);
      issue(MODE_READ, 64'h4000, DEF_MAX_SPAN_BYTES + 1);
      issue(MODE_REGISTER, 64'h4000, 8, DEF_MAX_SPAN_BYTES + 1);
      // store boundary: start past the end, span crossing it, last granule
      issue(MODE_UNPOISON, 64'h8_0000, 0);
      issue(MODE_UNPOISON, 64'h7_FFF8, 16);
      issue(MODE_POISON, 64'h7_FFF8, 8, 0, 0);
      // total inside the rounded object end: no redzone
      issue(MODE_REGISTER, 64'h5000, 5, 8);
      // top of the address space: outside the window for checks, out of store otherwise
      issue(MODE_READ, '1, 1);
      issue(MODE_POISON, '1, 8, 0, 8'h55);
      drain();

      // random phases, each under its own register setting
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: configure(1'b1, 64'h0, 64'h4_0000, RESET_CODE, POISON_MIN);
            1: begin
               base = {$urandom, $urandom};
               configure(1'b1, base, base + 64'h8_0000, 8'($urandom_range(249, 255)),
                         8'($urandom_range(249, 255)));
            end
            2: configure(1'b1, 64'hFFFF_FFFF_FFF8_0000, '1, FREED_RESET, 8'd252);
            3: configure(1'b1, 64'hFFFF_FFFF_FFF8_0003, '1, 8'($urandom_range(249, 255)),
                         RESET_CODE);
            default: configure(1'b0, 64'h5, 64'h2_0005, 8'd250, 8'd253);
         endcase
         // one whole phase runs without idling on either side
         steady = (p == 2);
         target = items_sent + 215;
         while (items_sent < target) begin
            if ($urandom_range(0, 99) < 70) object_life();
            else noise_item();
         end
         drain();
         steady = 1'b0;
      end

      // late or extra results would be caught during this settle
      repeat (40) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.outcomes.size() == 0) begin
         $display("shadow_memory_access_checker_unit_test: PASS");
      end else begin
         $display("shadow_memory_access_checker_unit_test: FAIL");
      end
      $finish;
   end

endmodule
